// File: hw/rtl/mbg_pkg.sv
package mbg_pkg;

	// Input opcodes.
	localparam logic [1:0] OPC_START = 2'd0;
	localparam logic [1:0] OPC_STEP  = 2'd1;
	localparam logic [1:0] OPC_READ  = 2'd2;

	// Result actions.
	localparam logic [2:0] ACT_STARTED  = 3'd0;
	localparam logic [2:0] ACT_CARVED   = 3'd1;
	localparam logic [2:0] ACT_BACKED   = 3'd2;
	localparam logic [2:0] ACT_COMPLETE = 3'd3;
	localparam logic [2:0] ACT_READ     = 3'd4;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 6;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'd1;

	// Cell entry: bit 4 is the visited mark, bits 3:0 the open walls.
	localparam int VISITED_BIT = 4;

	// Width that holds any grid dimension and its neighbors' coordinates.
	localparam int DIM_W = 9;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_CLR,
		OP_INIT,
		OP_SKIP,
		OP_RD_N,
		OP_RD_E,
		OP_RD_S,
		OP_RD_W,
		OP_RD_TOP,
		OP_SEL,
		OP_WR_NB,
		OP_WR_TOP,
		OP_POP_TOP,
		OP_RD_Q,
		OP_RD_DATA
	} dp_op_t;

	typedef struct packed {
		logic   latch;
		logic   emit;
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic step_ok;
		logic has_cand;
		logic clr_last;
	} dp_status_t;

endpackage

// File: hw/rtl/mbg_datapath.sv
module mbg_datapath import mbg_pkg::*; #(
	parameter int MAX_COLUMNS = 32,
	parameter int MAX_ROWS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dp_cmd_t              cmd,
	output dp_status_t           status,
	input  logic [15:0]          random_word,
	input  logic [4:0]           query_x,
	input  logic [4:0]           query_y,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output logic                 result_strobe,
	output logic [2:0]           action,
	output logic [4:0]           cell_x,
	output logic [4:0]           cell_y,
	output logic [1:0]           carve_direction,
	output logic [3:0]           path_bits,
	output logic                 cell_visited,
	output logic                 maze_done
);

	localparam int CELLS = MAX_COLUMNS * MAX_ROWS;
	localparam int XW = $clog2(MAX_COLUMNS);
	localparam int YW = $clog2(MAX_ROWS);
	localparam int AW = $clog2(CELLS);
	localparam int DW = $clog2(CELLS + 1);

	logic [CFG_DATA_W-1:0] width_q, height_q;
	logic [15:0] rnd_q;
	logic [4:0] qx_q, qy_q;
	logic [XW-1:0] top_x_q;
	logic [YW-1:0] top_y_q;
	logic [DW-1:0] depth_q, visited_q;
	logic started_q;
	logic [3:0] free_q;
	logic [1:0] dir_q;
	logic [AW-1:0] clr_q;
	logic [4:0] rd_data_q;
	logic [XW+YW-1:0] stk_rd_q;
	logic [2:0] res_action_q;
	logic [4:0] res_x_q, res_y_q;
	logic [1:0] res_dir_q;
	logic [3:0] res_pb_q;
	logic res_vis_q;
	logic strobe_q, done_q;

	logic [4:0] cell_mem [CELLS];
	logic [XW+YW-1:0] stk_mem [CELLS];

	logic [DIM_W-1:0] w_eff, h_eff, tx, ty;
	logic [2*DIM_W-1:0] total;
	logic done_now;
	logic [3:0] nvalid;
	logic [XW-1:0] nbx [4];
	logic [YW-1:0] nby [4];
	logic [AW-1:0] nb_addr [4];
	logic [AW-1:0] top_addr, q_addr, ra, wa, stk_ra;
	logic [4:0] wd;
	logic re, we, stk_we, q_in;
	logic [AW-1:0] stk_wa;
	logic [XW+YW-1:0] stk_wd;
	logic [2:0] n_free, cnt;
	logic [1:0] k, dir_sel;
	logic found;

	function automatic logic [AW-1:0] cell_addr(input logic [XW-1:0] x, input logic [YW-1:0] y);
		cell_addr = AW'(y) * AW'(MAX_COLUMNS) + AW'(x);
	endfunction

	// Residue of a 16-bit word modulo three: base-4 digits all weigh one.
	function automatic logic [1:0] mod3(input logic [15:0] v);
		logic [4:0] s;
		logic [3:0] s2;
		logic [2:0] s3;
		s = '0;
		for (int i = 0; i < 8; i++) begin
			s = s + 5'(v[2*i +: 2]);
		end
		s2 = 4'(s[4:2]) + 4'(s[1:0]);
		s3 = 3'(s2[3:2]) + 3'(s2[1:0]);
		if (s3 >= 3'd3) begin
			s3 = s3 - 3'd3;
		end
		mod3 = s3[1:0];
	endfunction

	always_comb begin
		if (width_q == '0) begin
			w_eff = DIM_W'(1);
		end else if (DIM_W'(width_q) > DIM_W'(MAX_COLUMNS)) begin
			w_eff = DIM_W'(MAX_COLUMNS);
		end else begin
			w_eff = DIM_W'(width_q);
		end
		if (height_q == '0) begin
			h_eff = DIM_W'(1);
		end else if (DIM_W'(height_q) > DIM_W'(MAX_ROWS)) begin
			h_eff = DIM_W'(MAX_ROWS);
		end else begin
			h_eff = DIM_W'(height_q);
		end
	end

	assign total = (2*DIM_W)'(w_eff) * (2*DIM_W)'(h_eff);
	assign done_now = started_q && ((2*DIM_W)'(visited_q) >= total);

	assign tx = DIM_W'(top_x_q);
	assign ty = DIM_W'(top_y_q);

	// A neighbor exists only inside the grid as it is sized right now.
	assign nvalid[0] = (tx < w_eff) && (ty != '0) && ((ty - DIM_W'(1)) < h_eff);
	assign nvalid[1] = (ty < h_eff) && ((tx + DIM_W'(1)) < w_eff);
	assign nvalid[2] = (tx < w_eff) && ((ty + DIM_W'(1)) < h_eff);
	assign nvalid[3] = (ty < h_eff) && (tx != '0) && ((tx - DIM_W'(1)) < w_eff);

	always_comb begin
		nbx[0] = top_x_q;
		nby[0] = top_y_q - YW'(1);
		nbx[1] = top_x_q + XW'(1);
		nby[1] = top_y_q;
		nbx[2] = top_x_q;
		nby[2] = top_y_q + YW'(1);
		nbx[3] = top_x_q - XW'(1);
		nby[3] = top_y_q;
		for (int i = 0; i < 4; i++) begin
			nb_addr[i] = cell_addr(nbx[i], nby[i]);
		end
	end

	assign top_addr = cell_addr(top_x_q, top_y_q);
	assign q_addr = cell_addr(XW'(qx_q), YW'(qy_q));
	assign q_in = (DIM_W'(qx_q) < DIM_W'(MAX_COLUMNS)) && (DIM_W'(qy_q) < DIM_W'(MAX_ROWS));

	// Pick the k-th free neighbor in north, east, south, west order.
	always_comb begin
		n_free = '0;
		for (int i = 0; i < 4; i++) begin
			n_free = n_free + 3'(free_q[i]);
		end
		case (n_free)
			3'd2: k = {1'b0, rnd_q[0]};
			3'd3: k = mod3(rnd_q);
			3'd4: k = rnd_q[1:0];
			default: k = 2'd0;
		endcase
		cnt = '0;
		found = 1'b0;
		dir_sel = 2'd0;
		for (int i = 0; i < 4; i++) begin
			if (free_q[i] && !found && cnt == {1'b0, k}) begin
				dir_sel = 2'(i);
				found = 1'b1;
			end
			cnt = cnt + 3'(free_q[i]);
		end
	end

	assign status.step_ok = started_q && !done_now && (depth_q != '0);
	assign status.has_cand = |free_q;
	assign status.clr_last = (clr_q == AW'(CELLS - 1));

	always_comb begin
		re = 1'b0;
		ra = top_addr;
		we = 1'b0;
		wa = top_addr;
		wd = '0;
		case (cmd.op)
			OP_CLR: begin
				we = 1'b1;
				wa = clr_q;
			end
			OP_INIT: begin
				we = 1'b1;
				wa = '0;
				wd = 5'(1 << VISITED_BIT);
			end
			OP_RD_N: begin
				re = 1'b1;
				ra = nb_addr[0];
			end
			OP_RD_E: begin
				re = 1'b1;
				ra = nb_addr[1];
			end
			OP_RD_S: begin
				re = 1'b1;
				ra = nb_addr[2];
			end
			OP_RD_W: begin
				re = 1'b1;
				ra = nb_addr[3];
			end
			OP_RD_TOP: begin
				re = 1'b1;
			end
			OP_RD_Q: begin
				re = 1'b1;
				ra = q_addr;
			end
			OP_WR_NB: begin
				// A cell not yet visited has no open walls, so no merge is needed.
				we = 1'b1;
				wa = nb_addr[dir_q];
				wd = {1'b1, 4'(4'b0001 << (dir_q ^ 2'd2))};
			end
			OP_WR_TOP: begin
				we = 1'b1;
				wd = rd_data_q | {1'b0, 4'(4'b0001 << dir_q)};
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		stk_we = 1'b0;
		stk_wa = '0;
		stk_wd = '0;
		if (cmd.op == OP_WR_NB && depth_q < DW'(CELLS)) begin
			stk_we = 1'b1;
			stk_wa = depth_q[AW-1:0];
			stk_wd = {nby[dir_q], nbx[dir_q]};
		end else if (cmd.op == OP_INIT) begin
			stk_we = 1'b1;
		end
	end

	assign stk_ra = AW'(depth_q - DW'(2));

	always_ff @(posedge clk) begin
		if (we) begin
			cell_mem[wa] <= wd;
		end
		if (re) begin
			rd_data_q <= cell_mem[ra];
		end
	end

	always_ff @(posedge clk) begin
		if (stk_we) begin
			stk_mem[stk_wa] <= stk_wd;
		end
		if (cmd.op == OP_SEL) begin
			stk_rd_q <= stk_mem[stk_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= CFG_DATA_W'(8);
			height_q <= CFG_DATA_W'(8);
			top_x_q <= '0;
			top_y_q <= '0;
			depth_q <= '0;
			visited_q <= '0;
			started_q <= 1'b0;
			clr_q <= '0;
			strobe_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_GRID_WIDTH: width_q <= wr_data;
					REG_GRID_HEIGHT: height_q <= wr_data;
					default: begin
					end
				endcase
			end
			strobe_q <= cmd.emit;
			if (cmd.emit) begin
				done_q <= done_now;
			end
			case (cmd.op)
				OP_CLR: clr_q <= status.clr_last ? '0 : clr_q + AW'(1);
				OP_INIT: begin
					depth_q <= DW'(1);
					visited_q <= DW'(1);
					started_q <= 1'b1;
					top_x_q <= '0;
					top_y_q <= '0;
				end
				OP_SEL: begin
					if (!status.has_cand) begin
						depth_q <= depth_q - DW'(1);
					end
				end
				OP_WR_NB: begin
					if (depth_q < DW'(CELLS)) begin
						depth_q <= depth_q + DW'(1);
					end
					visited_q <= visited_q + DW'(1);
				end
				OP_WR_TOP: begin
					top_x_q <= nbx[dir_q];
					top_y_q <= nby[dir_q];
				end
				OP_POP_TOP: begin
					if (depth_q != '0) begin
						top_x_q <= stk_rd_q[XW-1:0];
						top_y_q <= stk_rd_q[XW+YW-1:XW];
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			rnd_q <= random_word;
			qx_q <= query_x;
			qy_q <= query_y;
		end
		case (cmd.op)
			OP_RD_E: free_q[0] <= nvalid[0] && !rd_data_q[VISITED_BIT];
			OP_RD_S: free_q[1] <= nvalid[1] && !rd_data_q[VISITED_BIT];
			OP_RD_W: free_q[2] <= nvalid[2] && !rd_data_q[VISITED_BIT];
			OP_RD_TOP: free_q[3] <= nvalid[3] && !rd_data_q[VISITED_BIT];
			OP_SEL: dir_q <= dir_sel;
			default: begin
			end
		endcase
		case (cmd.op)
			OP_INIT, OP_SKIP: begin
				res_action_q <= (cmd.op == OP_INIT) ? ACT_STARTED : ACT_COMPLETE;
				res_x_q <= '0;
				res_y_q <= '0;
				res_dir_q <= '0;
				res_pb_q <= '0;
				res_vis_q <= 1'b0;
			end
			OP_POP_TOP: begin
				res_action_q <= ACT_BACKED;
				res_x_q <= (depth_q != '0) ? 5'(stk_rd_q[XW-1:0]) : 5'd0;
				res_y_q <= (depth_q != '0) ? 5'(stk_rd_q[XW+YW-1:XW]) : 5'd0;
				res_dir_q <= '0;
				res_pb_q <= '0;
				res_vis_q <= 1'b0;
			end
			OP_WR_TOP: begin
				res_action_q <= ACT_CARVED;
				res_x_q <= 5'(nbx[dir_q]);
				res_y_q <= 5'(nby[dir_q]);
				res_dir_q <= dir_q;
				res_pb_q <= '0;
				res_vis_q <= 1'b0;
			end
			OP_RD_DATA: begin
				res_action_q <= ACT_READ;
				res_x_q <= qx_q;
				res_y_q <= qy_q;
				res_dir_q <= '0;
				res_pb_q <= q_in ? rd_data_q[3:0] : 4'd0;
				res_vis_q <= q_in && rd_data_q[VISITED_BIT];
			end
			default: begin
			end
		endcase
	end

	assign result_strobe = strobe_q;
	assign action = res_action_q;
	assign cell_x = res_x_q;
	assign cell_y = res_y_q;
	assign carve_direction = res_dir_q;
	assign path_bits = res_pb_q;
	assign cell_visited = res_vis_q;
	assign maze_done = done_q;

endmodule

// File: hw/rtl/mbg_ctrl.sv
module mbg_ctrl import mbg_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] opcode,
	input  dp_status_t status,
	output dp_cmd_t    cmd,
	output logic       busy
);

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_INIT, S_SKIP, S_N, S_E, S_S, S_W, S_TOP,
		S_SEL, S_WNB, S_WTOP, S_POPW, S_RDQ, S_RDD, S_RESP
	} state_t;

	state_t state_q;
	logic init_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			init_q <= 1'b0;
		end else begin
			case (state_q)
				S_CLR: begin
					if (status.clr_last) begin
						state_q <= init_q ? S_INIT : S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						case (opcode)
							OPC_START: begin
								init_q <= 1'b1;
								state_q <= S_CLR;
							end
							OPC_STEP: state_q <= status.step_ok ? S_N : S_SKIP;
							OPC_READ: state_q <= S_RDQ;
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_INIT: state_q <= S_RESP;
				S_SKIP: state_q <= S_RESP;
				S_N: state_q <= S_E;
				S_E: state_q <= S_S;
				S_S: state_q <= S_W;
				S_W: state_q <= S_TOP;
				S_TOP: state_q <= S_SEL;
				S_SEL: state_q <= status.has_cand ? S_WNB : S_POPW;
				S_WNB: state_q <= S_WTOP;
				S_WTOP: state_q <= S_RESP;
				S_POPW: state_q <= S_RESP;
				S_RDQ: state_q <= S_RDD;
				S_RDD: state_q <= S_RESP;
				S_RESP: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd.latch = (state_q == S_IDLE) && start;
		cmd.emit = (state_q == S_RESP);
		case (state_q)
			S_CLR: cmd.op = OP_CLR;
			S_INIT: cmd.op = OP_INIT;
			S_SKIP: cmd.op = OP_SKIP;
			S_N: cmd.op = OP_RD_N;
			S_E: cmd.op = OP_RD_E;
			S_S: cmd.op = OP_RD_S;
			S_W: cmd.op = OP_RD_W;
			S_TOP: cmd.op = OP_RD_TOP;
			S_SEL: cmd.op = OP_SEL;
			S_WNB: cmd.op = OP_WR_NB;
			S_WTOP: cmd.op = OP_WR_TOP;
			S_POPW: cmd.op = OP_POP_TOP;
			S_RDQ: cmd.op = OP_RD_Q;
			S_RDD: cmd.op = OP_RD_DATA;
			default: cmd.op = OP_NONE;
		endcase
	end

	assign busy = (state_q != S_IDLE);

endmodule

// File: hw/rtl/maze_backtracker_generator_top.sv
// Channel   Ports                                          Handshake
// command   opcode, random_word, query_x, query_y          start & !busy
// result    action, cell_x, cell_y, carve_direction,       result_strobe, one cycle
//           path_bits, cell_visited, maze_done
// config    wr_index, wr_data                              wr_en
//
// One word at a time; busy is low again in the cycle the result strobe is high.
// A step reads four neighbors and the top cell from the cell store, one access per
// state, then writes two cells when it carves. After reset a clearing pass over
// every cell keeps busy high; start runs the same pass. The receiver cannot stall
// results.
module maze_backtracker_generator_top import mbg_pkg::*; #(
	parameter int MAX_COLUMNS = 32,
	parameter int MAX_ROWS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [1:0]            opcode,
	input  logic [15:0]           random_word,
	input  logic [4:0]            query_x,
	input  logic [4:0]            query_y,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output logic                  result_strobe,
	output logic [2:0]            action,
	output logic [4:0]            cell_x,
	output logic [4:0]            cell_y,
	output logic [1:0]            carve_direction,
	output logic [3:0]            path_bits,
	output logic                  cell_visited,
	output logic                  maze_done
);

	dp_cmd_t cmd;
	dp_status_t status;

	mbg_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.opcode(opcode),
		.status(status),
		.cmd(cmd),
		.busy(busy)
	);

	mbg_datapath #(
		.MAX_COLUMNS(MAX_COLUMNS),
		.MAX_ROWS(MAX_ROWS)
	) u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.status(status),
		.random_word(random_word),
		.query_x(query_x),
		.query_y(query_y),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.result_strobe(result_strobe),
		.action(action),
		.cell_x(cell_x),
		.cell_y(cell_y),
		.carve_direction(carve_direction),
		.path_bits(path_bits),
		.cell_visited(cell_visited),
		.maze_done(maze_done)
	);

endmodule
